@@ design/sbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcs_pkg
// Shared types and constants for the stable bucket counting sort block.
// ----------------------------------------------------------------------------
package sbcs_pkg;

   localparam int KEY_PORT_W  = 16;
   localparam int SECOND_W    = 31;
   localparam int POS_W       = 31;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_OFFSET = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_KEY_MODE    = 1'b1;

   typedef enum logic [1:0] {
      SEQ_LOAD,
      SEQ_SCAN,
      SEQ_TAIL,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      logic clear_prev;
      logic set_prev;
      logic clear_best;
      logic sample;
   } cmp_ctrl_type;

endpackage

@@ design/sbcs_store.sv @@
// ----------------------------------------------------------------------------
// sbcs_store
// Item store: key and second key per arrival index, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module sbcs_store #(
   parameter int BLOCK_DEPTH = 64,
   parameter int KEY_BITS    = 16,
   parameter int IDX_W       = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [KEY_BITS-1:0]           wr_key,
   input  logic [sbcs_pkg::SECOND_W-1:0] wr_second,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [KEY_BITS-1:0]           rd_key,
   output logic [sbcs_pkg::SECOND_W-1:0] rd_second
);

   logic [KEY_BITS-1:0]           key_store_ff    [BLOCK_DEPTH];
   logic [sbcs_pkg::SECOND_W-1:0] second_store_ff [BLOCK_DEPTH];
   logic [KEY_BITS-1:0]           rd_key_ff;
   logic [sbcs_pkg::SECOND_W-1:0] rd_second_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_store_ff[wr_addr]    <= wr_key;
         second_store_ff[wr_addr] <= wr_second;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff    <= key_store_ff[rd_addr];
      rd_second_ff <= second_store_ff[rd_addr];
   end

   assign rd_key    = rd_key_ff;
   assign rd_second = rd_second_ff;

endmodule

@@ design/sbcs_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// sbcs_cmp_unit
// Shared compare unit: over one scan, finds the smallest (key, index) pair
// above the previously emitted one.
// ----------------------------------------------------------------------------
module sbcs_cmp_unit #(
   parameter int KEY_BITS = 16,
   parameter int IDX_W    = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sbcs_pkg::cmp_ctrl_type        ctrl,
   input  logic [KEY_BITS-1:0]           cand_key,
   input  logic [IDX_W-1:0]              cand_idx,
   input  logic [sbcs_pkg::SECOND_W-1:0] cand_second,
   output logic                          best_valid,
   output logic [KEY_BITS-1:0]           best_key,
   output logic [IDX_W-1:0]              best_idx,
   output logic [sbcs_pkg::SECOND_W-1:0] best_second
);

   localparam int TAG_W = KEY_BITS + IDX_W;

   logic [TAG_W-1:0]              cand_tag;
   logic [TAG_W-1:0]              prev_ff, prev_in;
   logic                          have_prev_ff, have_prev_in;
   logic [TAG_W-1:0]              best_ff, best_in;
   logic                          best_valid_ff, best_valid_in;
   logic [sbcs_pkg::SECOND_W-1:0] best_second_ff, best_second_in;
   logic                          qualifies;
   logic                          better;
   logic                          take;

   assign cand_tag  = {cand_key, cand_idx};
   assign qualifies = !have_prev_ff || (cand_tag > prev_ff);
   assign better    = !best_valid_ff || (cand_tag < best_ff);
   assign take      = ctrl.sample && qualifies && better;

   always_comb begin
      prev_in        = prev_ff;
      have_prev_in   = have_prev_ff;
      best_in        = best_ff;
      best_valid_in  = best_valid_ff;
      best_second_in = best_second_ff;
      if (ctrl.clear_prev) begin
         have_prev_in = 1'b0;
      end else if (ctrl.set_prev) begin
         prev_in      = best_ff;
         have_prev_in = 1'b1;
      end
      if (ctrl.clear_best) begin
         best_valid_in = 1'b0;
      end else if (take) begin
         best_in        = cand_tag;
         best_second_in = cand_second;
         best_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         have_prev_ff  <= have_prev_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff        <= prev_in;
      best_ff        <= best_in;
      best_second_ff <= best_second_in;
   end

   assign best_valid  = best_valid_ff;
   assign best_key    = best_ff[TAG_W-1:IDX_W];
   assign best_idx    = best_ff[IDX_W-1:0];
   assign best_second = best_second_ff;

endmodule

@@ design/sbcs_seq.sv @@
// ----------------------------------------------------------------------------
// sbcs_seq
// Sequencer: loads the block, then runs one store scan per sorted result.
// ----------------------------------------------------------------------------
module sbcs_seq #(
   parameter int BLOCK_DEPTH = 64,
   parameter int IDX_W       = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_item,
   input  logic                   out_free,
   output logic                   req_stall,
   output logic                   wr_en,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [IDX_W-1:0]       rd_addr,
   output logic [IDX_W-1:0]       cand_idx,
   output sbcs_pkg::cmp_ctrl_type cmp_ctrl,
   output logic                   emit,
   output logic                   emit_last,
   output logic                   overflow
);

   localparam int CNT_W = $clog2(BLOCK_DEPTH + 1);

   sbcs_pkg::seq_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] rank_ff, rank_in;
   logic [CNT_W-1:0] last_cnt;
   logic [IDX_W-1:0] last_idx;
   logic             accept;
   logic             full;
   logic             start;
   logic             issue;

   assign last_cnt = count_ff - CNT_W'(1);
   assign last_idx = last_cnt[IDX_W-1:0];
   assign full     = (count_ff == CNT_W'(BLOCK_DEPTH));
   assign accept   = req_valid && !req_stall;
   assign start    = accept && req_last_item;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbcs_pkg::SEQ_LOAD: begin
            if (start) state_in = sbcs_pkg::SEQ_SCAN;
         end
         sbcs_pkg::SEQ_SCAN: begin
            if (scan_ff == last_idx) state_in = sbcs_pkg::SEQ_TAIL;
         end
         sbcs_pkg::SEQ_TAIL: begin
            state_in = sbcs_pkg::SEQ_EMIT;
         end
         sbcs_pkg::SEQ_EMIT: begin
            if (out_free) begin
               state_in = (rank_ff == last_idx) ? sbcs_pkg::SEQ_LOAD : sbcs_pkg::SEQ_SCAN;
            end
         end
         default: state_in = sbcs_pkg::SEQ_LOAD;
      endcase
   end

   always_comb begin
      req_stall           = (state_ff != sbcs_pkg::SEQ_LOAD);
      issue               = (state_ff == sbcs_pkg::SEQ_SCAN);
      emit                = (state_ff == sbcs_pkg::SEQ_EMIT) && out_free;
      emit_last           = (rank_ff == last_idx);
      wr_en               = accept && !full;
      wr_addr             = count_ff[IDX_W-1:0];
      rd_addr             = scan_ff;
      cand_idx            = rd_idx_ff;
      overflow            = ovf_ff;
      cmp_ctrl.clear_prev = start;
      cmp_ctrl.set_prev   = emit;
      cmp_ctrl.clear_best = start || (emit && !emit_last);
      cmp_ctrl.sample     = rd_valid_ff;
   end

   always_comb begin
      scan_in     = issue ? scan_ff + IDX_W'(1) : '0;
      rd_valid_in = issue;
      rd_idx_in   = scan_ff;
      rank_in     = rank_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      if (start) begin
         rank_in = '0;
      end else if (emit) begin
         rank_in = rank_ff + IDX_W'(1);
      end
      if (emit && emit_last) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (wr_en) count_in = count_ff + CNT_W'(1);
         if (accept && full) ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sbcs_pkg::SEQ_LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
         rank_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         scan_ff     <= scan_in;
         rd_valid_ff <= rd_valid_in;
         rank_ff     <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
   end

endmodule

@@ design/stable_bucket_counting_sort.sv @@
// ----------------------------------------------------------------------------
// stable_bucket_counting_sort
// Stable sort of a block of bucketed items, each result tagged with its
// arrival index plus a configured position offset.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  bucket_key, second_key, last_item
//   rsp_      out        rsp_valid/rsp_stall  sorted_key/second/position, last_out,
//                                             overflow
//   csr_      in         csr_write            csr_index, csr_data
//
// Loading takes one transaction per cycle. After the last item, each sorted
// result costs one scan of the n stored items through the shared compare
// unit, read one at a time through the single store read port. The next
// block loads while the final result waits. Reset is synchronous, needs no
// clearing pass; a stalled result only holds up the following scan's emit
// step.
// ----------------------------------------------------------------------------
module stable_bucket_counting_sort #(
   parameter int BLOCK_DEPTH = 64,
   parameter int KEY_BITS    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sbcs_pkg::KEY_PORT_W-1:0]  req_bucket_key,
   input  logic [sbcs_pkg::SECOND_W-1:0]    req_second_key,
   input  logic                             req_last_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sbcs_pkg::KEY_PORT_W-1:0]  rsp_sorted_key,
   output logic [sbcs_pkg::SECOND_W-1:0]    rsp_sorted_second,
   output logic [sbcs_pkg::POS_W-1:0]       rsp_sorted_position,
   output logic                             rsp_last_out,
   output logic                             rsp_overflow,
   input  logic                             csr_write,
   input  logic [sbcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbcs_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(BLOCK_DEPTH);

   logic [sbcs_pkg::POS_W-1:0]      offset_ff, offset_in;
   logic                            two_key_ff, two_key_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sbcs_pkg::KEY_PORT_W-1:0] key_ff, key_in;
   logic [sbcs_pkg::SECOND_W-1:0]   second_ff, second_in;
   logic [sbcs_pkg::POS_W-1:0]      position_ff, position_in;
   logic                            last_ff, last_in;
   logic                            ovf_out_ff, ovf_out_in;

   logic                          out_free;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [IDX_W-1:0]              rd_addr;
   logic [IDX_W-1:0]              cand_idx;
   logic [KEY_BITS-1:0]           rd_key;
   logic [sbcs_pkg::SECOND_W-1:0] rd_second;
   logic [sbcs_pkg::SECOND_W-1:0] wr_second;
   sbcs_pkg::cmp_ctrl_type        cmp_ctrl;
   logic                          emit;
   logic                          emit_last;
   logic                          overflow;
   logic                          best_valid;
   logic [KEY_BITS-1:0]           best_key;
   logic [IDX_W-1:0]              best_idx;
   logic [sbcs_pkg::SECOND_W-1:0] best_second;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_second = two_key_ff ? req_second_key : '0;

   sbcs_seq #(
      .BLOCK_DEPTH (BLOCK_DEPTH),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .out_free      (out_free),
      .req_stall     (req_stall),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr),
      .cand_idx      (cand_idx),
      .cmp_ctrl      (cmp_ctrl),
      .emit          (emit),
      .emit_last     (emit_last),
      .overflow      (overflow)
   );

   sbcs_store #(
      .BLOCK_DEPTH (BLOCK_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_key    (req_bucket_key[KEY_BITS-1:0]),
      .wr_second (wr_second),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_second (rd_second)
   );

   sbcs_cmp_unit #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
   ) u_cmp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cmp_ctrl),
      .cand_key    (rd_key),
      .cand_idx    (cand_idx),
      .cand_second (rd_second),
      .best_valid  (best_valid),
      .best_key    (best_key),
      .best_idx    (best_idx),
      .best_second (best_second)
   );

   always_comb begin
      offset_in  = offset_ff;
      two_key_in = two_key_ff;
      if (csr_write) begin
         case (csr_index)
            sbcs_pkg::CSR_POSITION_OFFSET: offset_in  = csr_data;
            sbcs_pkg::CSR_TWO_KEY_MODE:    two_key_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      key_in       = key_ff;
      second_in    = second_ff;
      position_in  = position_ff;
      last_in      = last_ff;
      ovf_out_in   = ovf_out_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         key_in       = sbcs_pkg::KEY_PORT_W'(best_key);
         second_in    = best_second;
         position_in  = offset_ff + sbcs_pkg::POS_W'(best_idx);
         last_in      = emit_last;
         ovf_out_in   = overflow;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         two_key_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         two_key_ff   <= two_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      second_ff   <= second_in;
      position_ff <= position_in;
      last_ff     <= last_in;
      ovf_out_ff  <= ovf_out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sorted_key      = key_ff;
   assign rsp_sorted_second   = second_ff;
   assign rsp_sorted_position = position_ff;
   assign rsp_last_out        = last_ff;
   assign rsp_overflow        = ovf_out_ff;

   a_emit_has_best: assert property (@(posedge clock) disable iff (reset)
      emit |-> best_valid)
      else $error("emit without a selected item");

   a_no_scan_while_loading: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !cmp_ctrl.sample)
      else $error("store scan active while loading");

   a_block_end_reopens: assert property (@(posedge clock) disable iff (reset)
      emit && emit_last |=> !req_stall && rsp_valid && rsp_last_out)
      else $error("block end did not return to loading");

endmodule

@@ tb/tb_stable_bucket_counting_sort.sv @@
// ----------------------------------------------------------------------------
// tb_stable_bucket_counting_sort
// Loads blocks of bucketed items and checks every sorted transaction, field by
// field, against a behavioral predictor of the stable counting sort. A short
// directed table covers extremes, two-key mode, stability, position wrap and
// register changes inside a block. Random blocks follow: duplicate-heavy and
// full-range keys, full stores with dropped items, and bursty, stalling
// traffic on both channels.
// ----------------------------------------------------------------------------
module tb_stable_bucket_counting_sort;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH   = 64;
   localparam int SETTLE_CYCLES = STORE_DEPTH + 8;
   localparam int RANDOM_TARGET = 450;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_DIRECTED  = 20;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {KEYS_FEW, KEYS_ANY, KEYS_EDGES, KEYS_CLUSTER} key_style_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_TOGGLE
   } stall_style_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [sbcs_pkg::CSR_INDEX_W-1:0]  reg_index;
      logic [sbcs_pkg::CSR_DATA_W-1:0]   reg_value;
      logic [sbcs_pkg::KEY_PORT_W-1:0]   key;
      logic [sbcs_pkg::SECOND_W-1:0]     second;
      logic                              ends_block;
      logic                              has_typed;
      logic [sbcs_pkg::SECOND_W-1:0]     typed_second;
      logic [sbcs_pkg::POS_W-1:0]        typed_position;
   } stim_row_type;

   typedef struct packed {
      logic [sbcs_pkg::KEY_PORT_W-1:0] key;
      logic [sbcs_pkg::SECOND_W-1:0]   second;
      logic [sbcs_pkg::POS_W-1:0]      position;
      logic                            last_out;
      logic                            overflow;
   } sorted_entry_type;

   // Typed rows are single-item blocks: key echoes, last_out set, no overflow.
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'hFFFF, 31'h7FFF_FFFF,
        1'b1, 1'b1, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0000, 31'd0,
        1'b1, 1'b1, 31'd0, 31'd0},
      '{ROW_WRITE, sbcs_pkg::CSR_TWO_KEY_MODE, 31'd1, 16'h0000, 31'd0,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0000, 31'h7FFF_FFFF,
        1'b1, 1'b1, 31'h7FFF_FFFF, 31'd0},
      '{ROW_WRITE, sbcs_pkg::CSR_POSITION_OFFSET, 31'h7FFF_FFFF, 16'h0000, 31'd0,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h1234, 31'd1,
        1'b1, 1'b1, 31'd1, 31'h7FFF_FFFF},
      // equal keys keep arrival order, positions wrap past the top
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0005, 31'd10,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0003, 31'd11,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0005, 31'd12,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0000, 31'd13,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0003, 31'd14,
        1'b1, 1'b0, 31'd0, 31'd0},
      // mode and offset changed while a block is half loaded
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0009, 31'd20,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_WRITE, sbcs_pkg::CSR_TWO_KEY_MODE, 31'd0, 16'h0000, 31'd0,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0002, 31'd21,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_WRITE, sbcs_pkg::CSR_POSITION_OFFSET, 31'h4000_0000, 16'h0000, 31'd0,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0009, 31'd22,
        1'b1, 1'b0, 31'd0, 31'd0},
      // reverse order input
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'hFFFF, 31'h2AAA_AAAA,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h8000, 31'd0,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0001, 31'd0,
        1'b0, 1'b0, 31'd0, 31'd0},
      '{ROW_ITEM,  sbcs_pkg::CSR_POSITION_OFFSET, 31'd0, 16'h0000, 31'd0,
        1'b1, 1'b0, 31'd0, 31'd0}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [sbcs_pkg::KEY_PORT_W-1:0]  req_bucket_key = '0;
   logic [sbcs_pkg::SECOND_W-1:0]    req_second_key = '0;
   logic                             req_last_item = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [sbcs_pkg::KEY_PORT_W-1:0]  rsp_sorted_key;
   logic [sbcs_pkg::SECOND_W-1:0]    rsp_sorted_second;
   logic [sbcs_pkg::POS_W-1:0]       rsp_sorted_position;
   logic                             rsp_last_out;
   logic                             rsp_overflow;
   logic                             csr_write = 1'b0;
   logic [sbcs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sbcs_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // predictor state
   sorted_entry_type                pending_sorted[$];
   logic [sbcs_pkg::KEY_PORT_W-1:0] held_key [STORE_DEPTH];
   logic [sbcs_pkg::SECOND_W-1:0]   held_second [STORE_DEPTH];
   int                              held_count = 0;
   bit                              held_overflow = 1'b0;
   logic [sbcs_pkg::POS_W-1:0]      cfg_offset = '0;
   bit                              cfg_two_key = 1'b0;

   int                     fail_count = 0;
   int                     cycle_count = 0;
   int                     random_items = 0;
   int                     burst_left = 0;
   bit                     sender_gapless = 1'b0;
   stall_style_type        stall_style = STALL_NONE;
   int                     stall_tick = 0;

   stable_bucket_counting_sort #(
      .BLOCK_DEPTH(STORE_DEPTH),
      .KEY_BITS(16)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_bucket_key(req_bucket_key),
      .req_second_key(req_second_key),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sorted_key(rsp_sorted_key),
      .rsp_sorted_second(rsp_sorted_second),
      .rsp_sorted_position(rsp_sorted_position),
      .rsp_last_out(rsp_last_out),
      .rsp_overflow(rsp_overflow),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Stores one item; on the block's last item, emits the block in stable key order.
   task automatic absorb_item(input logic [sbcs_pkg::KEY_PORT_W-1:0] key,
                              input logic [sbcs_pkg::SECOND_W-1:0] second,
                              input logic ends_block);
      int               order[$];
      int               slot;
      sorted_entry_type entry;
      if (held_count < STORE_DEPTH) begin
         held_key[held_count] = key;
         held_second[held_count] = cfg_two_key ? second : '0;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (ends_block) begin
         for (int i = 0; i < held_count; i++) begin
            slot = order.size();
            while (slot > 0 && held_key[order[slot - 1]] > held_key[i]) slot--;
            order.insert(slot, i);
         end
         foreach (order[p]) begin
            entry.key = held_key[order[p]];
            entry.second = held_second[order[p]];
            entry.position = cfg_offset + sbcs_pkg::POS_W'(order[p]);
            entry.last_out = (p == order.size() - 1);
            entry.overflow = held_overflow;
            pending_sorted.push_back(entry);
         end
         held_count = 0;
         held_overflow = 1'b0;
      end
   endtask

   task automatic send_item(input logic [sbcs_pkg::KEY_PORT_W-1:0] key,
                            input logic [sbcs_pkg::SECOND_W-1:0] second,
                            input logic ends_block, input logic has_typed,
                            input logic [sbcs_pkg::SECOND_W-1:0] typed_second,
                            input logic [sbcs_pkg::POS_W-1:0] typed_position);
      int               gap;
      int               queued;
      sorted_entry_type entry;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gapless) gap = 0;
         else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 20);
         else gap = $urandom_range(0, 4);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_bucket_key <= key;
      req_second_key <= second;
      req_last_item <= ends_block;
      do @(posedge clock); while (req_stall);
      queued = pending_sorted.size();
      absorb_item(key, second, ends_block);
      if (has_typed) begin
         while (pending_sorted.size() > queued) void'(pending_sorted.pop_back());
         entry.key = key;
         entry.second = typed_second;
         entry.position = typed_position;
         entry.last_out = 1'b1;
         entry.overflow = 1'b0;
         pending_sorted.push_back(entry);
      end
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sbcs_pkg::CSR_INDEX_W-1:0] index,
                            input logic [sbcs_pkg::CSR_DATA_W-1:0] value);
      drain_and_settle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == sbcs_pkg::CSR_POSITION_OFFSET) cfg_offset = value;
      else cfg_two_key = value[0];
   endtask

   function automatic logic [sbcs_pkg::KEY_PORT_W-1:0] pick_key(input key_style_type style);
      case (style)
         KEYS_FEW: return sbcs_pkg::KEY_PORT_W'($urandom_range(0, 3));
         KEYS_ANY: return sbcs_pkg::KEY_PORT_W'($urandom);
         KEYS_EDGES: begin
            case ($urandom_range(0, 3))
               0: return 16'h0000;
               1: return 16'hFFFF;
               2: return 16'h8000;
               default: return 16'h7FFF;
            endcase
         end
         default: return 16'hA5F0 + sbcs_pkg::KEY_PORT_W'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic send_block(input int count, input bit closed);
      key_style_type                 style;
      logic [sbcs_pkg::SECOND_W-1:0] second;
      style = key_style_type'($urandom_range(0, 3));
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 7))
            0: second = '0;
            1: second = '1;
            default: second = sbcs_pkg::SECOND_W'($urandom);
         endcase
         send_item(pick_key(style), second, closed && (k == count - 1), 1'b0, '0, '0);
         random_items++;
      end
   endtask

   // receiver stall pattern, restyled whenever its countdown runs out
   always @(negedge clock) begin
      if (stall_tick == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_tick <= $urandom_range(20, 150);
      end else begin
         stall_tick <= stall_tick - 1;
      end
      case (stall_style)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         default:      rsp_stall <= ~rsp_stall;
      endcase
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      sorted_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sorted.size() == 0) begin
            $error("sorted transaction with none expected: key 0x%0h position 0x%0h",
                   rsp_sorted_key, rsp_sorted_position);
            fail_count++;
         end else begin
            want = pending_sorted.pop_front();
            check_field("sorted_key", 32'(want.key), 32'(rsp_sorted_key));
            check_field("sorted_second", 32'(want.second), 32'(rsp_sorted_second));
            check_field("sorted_position", 32'(want.position), 32'(rsp_sorted_position));
            check_field("last_out", 32'(want.last_out), 32'(rsp_last_out));
            check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      stim_row_type               row;
      int                         phase;
      int                         phase_items;
      int                         size;
      logic [sbcs_pkg::POS_W-1:0] offset;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_WRITE) write_reg(row.reg_index, row.reg_value);
         else send_item(row.key, row.second, row.ends_block, row.has_typed,
                        row.typed_second, row.typed_position);
      end

      phase = 0;
      while (random_items < RANDOM_TARGET) begin
         sender_gapless = ($urandom_range(0, 3) == 0);
         case (phase % 4)
            0: offset = '0;
            1: offset = 31'h7FFF_FFFF - sbcs_pkg::POS_W'($urandom_range(0, 40));
            2: offset = sbcs_pkg::POS_W'($urandom);
            default: offset = 31'h7FFF_FFFF;
         endcase
         if ($urandom_range(0, 1) == 1) begin
            write_reg(sbcs_pkg::CSR_POSITION_OFFSET, offset);
            write_reg(sbcs_pkg::CSR_TWO_KEY_MODE, sbcs_pkg::CSR_DATA_W'(phase % 2 == 0));
         end else begin
            write_reg(sbcs_pkg::CSR_TWO_KEY_MODE, sbcs_pkg::CSR_DATA_W'(phase % 2 == 0));
            write_reg(sbcs_pkg::CSR_POSITION_OFFSET, offset);
         end
         phase_items = 0;
         while (phase_items < 55 && random_items < RANDOM_TARGET) begin
            // dropped last item early on, an exactly full store later
            if (phase == 0 && phase_items == 0) size = STORE_DEPTH + 1;
            else if (phase == 3 && phase_items == 0) size = STORE_DEPTH - held_count;
            else if ($urandom_range(0, 11) == 0)
               size = $urandom_range(STORE_DEPTH, STORE_DEPTH + 6);
            else if ($urandom_range(0, 3) == 0) size = $urandom_range(1, 2);
            else size = $urandom_range(3, 12);
            send_block(size, 1'b1);
            phase_items += size;
         end
         // open block carried across the next register writes
         if ($urandom_range(0, 2) == 0) send_block($urandom_range(1, 5), 1'b0);
         phase++;
      end
      send_block(1, 1'b1);

      drain_and_settle();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
